@@ sv/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the chained hash table
// Field widths, result status codes and the geometry of the bucket modulo unit.
// ----------------------------------------------------------------------------
package cht_pkg;

  // Widths of the request and result fields.
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int BIDX_W   = 4;
  localparam int RCNT_W   = 7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIND  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // The modulo unit consumes the key padded to 32 bits, four bits per cycle.
  localparam int MOD_W     = 32;
  localparam int MOD_DIG   = 4;
  localparam int MOD_STEPS = MOD_W / MOD_DIG;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [STATUS_W-1:0] status_t;

endpackage

@@ sv/cht_ram.sv @@
// ----------------------------------------------------------------------------
// cht_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/cht_mod.sv @@
// ----------------------------------------------------------------------------
// cht_mod: iterative key modulo unit
// Computes key modulo BUCKETS by shift, compare and subtract, four key bits
// per cycle starting at the most significant end.
// ----------------------------------------------------------------------------
module cht_mod
  import cht_pkg::*;
#(
  parameter int BUCKETS = 16,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  key_t          key,
  output logic          done,
  output logic [BW-1:0] rem
);

  localparam logic [BW:0] BMOD = (BW+1)'(BUCKETS);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0]     sh_r, sh_nxt;
  logic [BW-1:0]        rem_r, rem_nxt;
  logic [BW-1:0]        step_rem;

  // Four dependent compare-subtract steps on the narrow remainder.
  always_comb begin
    logic [BW:0] t;
    step_rem = rem_r;
    for (int i = 0; i < MOD_DIG; i++) begin
      t = {step_rem, sh_r[MOD_W-1-i]};
      if (t >= BMOD) begin
        t = t - BMOD;
      end
      step_rem = t[BW-1:0];
    end
  end

  // Sequencing of the digit steps.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = {1'b0, key};
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = step_rem;
      sh_nxt  = sh_r << MOD_DIG;
      cnt_nxt = cnt_r + MOD_CNT_W'(1);
      if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ sv/chained_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_core: hash table with separate chaining over a node pool
// Each request inserts a key at the tail of its bucket's chain or deletes
// every node that holds the key; one result comes back per request.
//
// Usage: a request is taken when in_valid is high and in_stall is low. The
// block then holds in_stall high until the request's result is loaded into
// the output register. The result is offered with out_valid and held until
// out_stall is low. A new request may be taken while a result still waits.
// Steps after the accepting edge: the bucket modulo unit (eight steps of four
// key bits, then a registered done), the bucket head read, then for an insert
// taking a free node and walking to the tail of the chain, for a delete
// checking each node on the chain and pushing each match onto the free list,
// then loading the result. The walk over the node link memory, which has one
// write port and one read port, goes one node per cycle.
// Reset: all chains are empty and every node is on the free list; a fill
// mark stands in for the initial free list links, so no clearing pass runs.
// While the receiver stalls, a finished result waits in the output stage.
// ----------------------------------------------------------------------------
module chained_hash_table_core
  import cht_pkg::*;
#(
  parameter int BUCKETS    = 16,
  parameter int POOL_NODES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  key_t              in_key_value,
  output logic              out_valid,
  input  logic              out_stall,
  output status_t           out_status,
  output logic [BIDX_W-1:0] out_bucket_index,
  output logic [RCNT_W-1:0] out_removed_count
);

  localparam int BW = $clog2(BUCKETS);
  localparam int NW = $clog2(POOL_NODES);
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HASH  = 4'd1;
  localparam logic [3:0] S_HRD   = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_IFREE = 4'd4;
  localparam logic [3:0] S_IWALK = 4'd5;
  localparam logic [3:0] S_DEL   = 4'd6;
  localparam logic [3:0] S_DFREE = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  function automatic logic in_pool(input logic [LW-1:0] n);
    return n < NIL;
  endfunction

  logic [3:0]        state_r, state_nxt;
  logic              req_r, req_nxt;
  key_t              key_r, key_nxt;
  logic [BW-1:0]     bucket_r, bucket_nxt;
  logic [LW-1:0]     free_head_r, free_head_nxt;
  logic [LW-1:0]     hw_r, hw_nxt;
  logic [NW-1:0]     new_r, new_nxt;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     prev_r, prev_nxt;
  logic [LW-1:0]     nxt_r, nxt_nxt;
  logic [LW-1:0]     steps_r, steps_nxt;
  logic [LW-1:0]     removed_r, removed_nxt;
  status_t           status_r, status_nxt;
  logic [BUCKETS-1:0] head_vld_r;
  logic [NW-1:0]     lra_r;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [BIDX_W-1:0] out_bucket_r;
  logic [RCNT_W-1:0] out_removed_r;
  logic              out_load;

  logic              mod_start;
  logic              mod_done;
  logic [BW-1:0]     mod_rem;

  logic              head_we;
  logic [LW-1:0]     head_wdata;
  logic [LW-1:0]     head_rdata;
  logic [LW-1:0]     head_eff;

  logic              link_we;
  logic [NW-1:0]     link_wa;
  logic [LW-1:0]     link_wd;
  logic [LW-1:0]     link_rdata;
  logic [LW-1:0]     link_eff;

  logic              val_we;
  key_t              val_rdata;
  logic [NW-1:0]     node_ra;
  logic [LW-1:0]     steps_inc;
  logic [LW-1:0]     removed_inc;

  // Bucket modulo unit.
  cht_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_key_value),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Chain head of each bucket.
  cht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (bucket_r),
    .wdata (head_wdata),
    .raddr (bucket_r),
    .rdata (head_rdata)
  );

  // Next link of each node, shared by the chains and the free list.
  cht_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_wa),
    .wdata (link_wd),
    .raddr (node_ra),
    .rdata (link_rdata)
  );

  // Key held by each node.
  cht_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (free_head_r[NW-1:0]),
    .wdata (key_r),
    .raddr (node_ra),
    .rdata (val_rdata)
  );

  // A bucket never written is empty; a node at or above the fill mark was
  // never allocated and still links to the next node of the initial free list.
  assign head_eff  = head_vld_r[bucket_r] ? head_rdata : NIL;
  assign link_eff  = (LW'(lra_r) >= hw_r) ? LW'(lra_r) + LW'(1) : link_rdata;
  assign steps_inc   = steps_r + LW'(1);
  assign removed_inc = removed_r + LW'(1);

  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // Request sequencer.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    bucket_nxt    = bucket_r;
    free_head_nxt = free_head_r;
    hw_nxt        = hw_r;
    new_nxt       = new_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    nxt_nxt       = nxt_r;
    steps_nxt     = steps_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    mod_start     = 1'b0;
    head_we       = 1'b0;
    head_wdata    = cur_r;
    link_we       = 1'b0;
    link_wa       = cur_r[NW-1:0];
    link_wd       = NIL;
    val_we        = 1'b0;
    node_ra       = '0;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          key_nxt   = in_key_value;
          mod_start = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          bucket_nxt = mod_rem;
          state_nxt  = S_HRD;
        end
      end
      S_HRD: begin
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        removed_nxt = '0;
        steps_nxt   = '0;
        prev_nxt    = NIL;
        cur_nxt     = head_eff;
        if (!req_r) begin
          if (!in_pool(free_head_r)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            node_ra   = free_head_r[NW-1:0];
            state_nxt = S_IFREE;
          end
        end else if (in_pool(head_eff)) begin
          node_ra   = head_eff[NW-1:0];
          state_nxt = S_DEL;
        end else begin
          status_nxt = ST_NOFIND;
          state_nxt  = S_FIN;
        end
      end
      S_IFREE: begin
        // Take the free head, store the key and terminate its link.
        new_nxt       = free_head_r[NW-1:0];
        free_head_nxt = link_eff;
        if (free_head_r >= hw_r) begin
          hw_nxt = hw_r + LW'(1);
        end
        val_we  = 1'b1;
        link_we = 1'b1;
        link_wa = free_head_r[NW-1:0];
        link_wd = NIL;
        if (in_pool(cur_r)) begin
          node_ra   = cur_r[NW-1:0];
          state_nxt = S_IWALK;
        end else begin
          head_we    = 1'b1;
          head_wdata = LW'(free_head_r[NW-1:0]);
          status_nxt = ST_DONE;
          state_nxt  = S_FIN;
        end
      end
      S_IWALK: begin
        // Follow the chain to its tail and hang the new node there.
        if (in_pool(link_eff) && (steps_r < NIL)) begin
          cur_nxt   = link_eff;
          steps_nxt = steps_inc;
          node_ra   = link_eff[NW-1:0];
        end else begin
          link_we    = 1'b1;
          link_wa    = cur_r[NW-1:0];
          link_wd    = LW'(new_r);
          status_nxt = ST_DONE;
          state_nxt  = S_FIN;
        end
      end
      S_DEL: begin
        // Check one node; a match is unlinked from its predecessor.
        nxt_nxt   = link_eff;
        steps_nxt = steps_inc;
        if (val_rdata == key_r) begin
          if (in_pool(prev_r)) begin
            link_we = 1'b1;
            link_wa = prev_r[NW-1:0];
            link_wd = link_eff;
          end else begin
            head_we    = 1'b1;
            head_wdata = link_eff;
          end
          state_nxt = S_DFREE;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_eff;
          if (in_pool(link_eff) && (steps_inc < NIL)) begin
            node_ra = link_eff[NW-1:0];
          end else begin
            status_nxt = (removed_r == '0) ? ST_NOFIND : ST_DONE;
            state_nxt  = S_FIN;
          end
        end
      end
      S_DFREE: begin
        // Push the removed node onto the free list.
        link_we       = 1'b1;
        link_wa       = cur_r[NW-1:0];
        link_wd       = free_head_r;
        free_head_nxt = cur_r;
        removed_nxt   = removed_inc;
        cur_nxt       = nxt_r;
        if (in_pool(nxt_r) && (steps_r < NIL)) begin
          node_ra   = nxt_r[NW-1:0];
          state_nxt = S_DEL;
        end else begin
          status_nxt = ST_DONE;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      hw_r        <= '0;
      head_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) begin
        head_vld_r[bucket_r] <= 1'b1;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    key_r     <= key_nxt;
    bucket_r  <= bucket_nxt;
    new_r     <= new_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    nxt_r     <= nxt_nxt;
    steps_r   <= steps_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    lra_r     <= node_ra;
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= status_r;
      out_bucket_r  <= BIDX_W'(bucket_r);
      out_removed_r <= (status_r == ST_FULL) ? '0 : RCNT_W'(removed_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_bucket_index  = out_bucket_r;
  assign out_removed_count = out_removed_r;

`ifndef SYNTH
  a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_HASH))
    else $error("accepted request did not start the modulo unit");

  a_mod_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_HASH))
    else $error("modulo result outside the hash phase");

  a_fill_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= NIL)
    else $error("fill mark ran past the node pool");

  a_nofind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_NOFIND || out_status_r == ST_FULL))
      |-> (out_removed_r == '0))
    else $error("removed count nonzero without removal");

  a_free_pop_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IFREE) |-> (free_head_r <= hw_r))
    else $error("free head lies beyond the fill mark");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for chained_hash_table_core
// A directed table of requests is followed by random traffic that builds and
// tears down chains, fills the node pool and clears it again. A behavioral
// copy of the table predicts each result that the directed table does not give,
// and each result is compared field by field with the oldest expected result
// while both sides idle and stall.
module tb;
  import cht_pkg::*;

  localparam int NBKT  = 16;
  localparam int NPOOL = 64;
  localparam int BKT_W  = $clog2(NBKT);
  localparam int NODE_W = $clog2(NPOOL);
  localparam logic [6:0] NIL = 7'(NPOOL);

  // Request types as the block decodes them.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam int DIR_N      = 20;
  localparam int SETTLE_CYC = 4 * NPOOL + 40;

  typedef struct packed {
    status_t             status;
    logic [BIDX_W-1:0]   bidx;
    logic [RCNT_W-1:0]   rcnt;
  } ht_result_t;

  typedef struct packed {
    logic       typed;
    ht_result_t res;
  } result_hint_t;

  typedef struct packed {
    logic       req;
    key_t       key;
    logic       typed;
    ht_result_t res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_req_type = 1'b0;
  key_t              in_key_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  status_t           out_status;
  logic [BIDX_W-1:0] out_bucket_index;
  logic [RCNT_W-1:0] out_removed_count;

  chained_hash_table_core #(
    .BUCKETS    (NBKT),
    .POOL_NODES (NPOOL)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_key_value      (in_key_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_bucket_index  (out_bucket_index),
    .out_removed_count (out_removed_count)
  );

  always #10 clk = ~clk;

  // Shadow copy of the hash table.
  logic [6:0] shadow_head [NBKT];
  key_t       shadow_key  [NPOOL];
  logic [6:0] shadow_next [NPOOL];
  logic [6:0] shadow_free;

  ht_result_t   pending_results [$];
  result_hint_t request_hints [$];

  int errors      = 0;
  int n_insert    = 0;
  int n_delete    = 0;
  int n_full      = 0;
  int n_nofind    = 0;
  int max_removed = 0;

  // Sender pacing.
  int burst_left = 0;
  bit no_gaps    = 1'b0;

  function automatic void shadow_reset();
    for (int i = 0; i < NBKT; i++) shadow_head[i] = NIL;
    for (int i = 0; i < NPOOL; i++) begin
      shadow_key[i]  = '0;
      shadow_next[i] = 7'(i + 1);
    end
    shadow_free = 7'd0;
  endfunction

  // Apply one request to the shadow table and return its result.
  function automatic ht_result_t shadow_apply(logic req, key_t key);
    ht_result_t r;
    int         b;
    int         steps;
    int         removed;
    logic [6:0] n, cur, prev, nxt;
    b       = int'(key % NBKT);
    removed = 0;
    steps   = 0;
    r.status = ST_DONE;
    r.bidx   = b[BIDX_W-1:0];
    if (req == REQ_INSERT) begin
      if (shadow_free >= NIL) begin
        r.status = ST_FULL;
      end else begin
        n = shadow_free;
        shadow_free                = shadow_next[n[NODE_W-1:0]];
        shadow_key[n[NODE_W-1:0]]  = key;
        shadow_next[n[NODE_W-1:0]] = NIL;
        cur = shadow_head[b[BKT_W-1:0]];
        if (cur >= NIL) begin
          shadow_head[b[BKT_W-1:0]] = n;
        end else begin
          while (shadow_next[cur[NODE_W-1:0]] < NIL && steps < NPOOL) begin
            cur = shadow_next[cur[NODE_W-1:0]];
            steps++;
          end
          shadow_next[cur[NODE_W-1:0]] = n;
        end
      end
    end else begin
      prev = NIL;
      cur  = shadow_head[b[BKT_W-1:0]];
      while (cur < NIL && steps < NPOOL) begin
        nxt = shadow_next[cur[NODE_W-1:0]];
        steps++;
        if (shadow_key[cur[NODE_W-1:0]] == key) begin
          if (prev < NIL) shadow_next[prev[NODE_W-1:0]] = nxt;
          else shadow_head[b[BKT_W-1:0]] = nxt;
          shadow_next[cur[NODE_W-1:0]] = shadow_free;
          shadow_free                  = cur;
          removed++;
        end else begin
          prev = cur;
        end
        cur = nxt;
      end
      r.status = (removed == 0) ? ST_NOFIND : ST_DONE;
    end
    r.rcnt = removed[RCNT_W-1:0];
    return r;
  endfunction

  // Returns a key that currently sits on some chain, or sets found to zero.
  function automatic key_t shadow_live_key(output bit found);
    found = 1'b0;
    for (int i = 0; i < NBKT; i++) begin
      if (shadow_head[i] < NIL) begin
        found = 1'b1;
        return shadow_key[shadow_head[i][NODE_W-1:0]];
      end
    end
    return '0;
  endfunction

  // Receiver: stall pattern that switches between calm, noisy, heavy and periodic modes.
  int stall_mode = 0;
  int mode_left  = 100;
  int stall_cyc  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cyc <= stall_cyc + 1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= (stall_cyc % 37) < 25;
        default: out_stall <= (stall_cyc % 3) == 0;
      endcase
    end
  end

  // Monitor: check each result, then predict each accepted request.
  always @(posedge clk) begin : monitor
    ht_result_t   got;
    ht_result_t   want;
    ht_result_t   pred;
    result_hint_t hint;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_bucket_index, out_removed_count};
        if (pending_results.size() == 0) begin
          $error("result with no request waiting: status %0d bucket %0d removed %0d",
                 got.status, got.bidx, got.rcnt);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (got.bidx !== want.bidx) begin
            $error("bucket_index: expected %0d, actual %0d", want.bidx, got.bidx);
            errors++;
          end
          if (got.rcnt !== want.rcnt) begin
            $error("removed_count: expected %0d, actual %0d", want.rcnt, got.rcnt);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        hint = (request_hints.size() != 0) ? request_hints.pop_front() : '0;
        pred = shadow_apply(in_req_type, in_key_value);
        if (in_req_type == REQ_INSERT) n_insert++;
        else n_delete++;
        if (pred.status == ST_FULL) n_full++;
        if (pred.status == ST_NOFIND) n_nofind++;
        if (int'(pred.rcnt) > max_removed) max_removed = int'(pred.rcnt);
        pending_results.push_back(hint.typed ? hint.res : pred);
      end
    end
  end

  // Offer one request and hold it until accepted, then apply the burst pacing.
  task automatic send_request(logic req, key_t key, logic typed = 1'b0,
                              ht_result_t res = '0);
    int gap;
    request_hints.push_back('{typed, res});
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_key_value <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // Delete every key still on a chain, one request at a time.
  task automatic clear_table();
    bit   found;
    key_t k;
    forever begin
      drain();
      k = shadow_live_key(found);
      if (!found) break;
      send_request(REQ_DELETE, k);
    end
  endtask

  // Directed table: extremes of the key, duplicates, head/middle/tail unlinks.
  stim_row_t dir_rows [DIR_N] = '{
    '{REQ_DELETE, 31'd0,          1'b1, '{ST_NOFIND, 4'd0,  7'd0}},
    '{REQ_DELETE, 31'h7FFFFFFF,   1'b1, '{ST_NOFIND, 4'd15, 7'd0}},
    '{REQ_INSERT, 31'h7FFFFFFF,   1'b1, '{ST_DONE,   4'd15, 7'd0}},
    '{REQ_INSERT, 31'd0,          1'b1, '{ST_DONE,   4'd0,  7'd0}},
    '{REQ_INSERT, 31'd0,          1'b1, '{ST_DONE,   4'd0,  7'd0}},
    '{REQ_INSERT, 31'd16,         1'b0, '0},
    '{REQ_INSERT, 31'd0,          1'b0, '0},
    '{REQ_INSERT, 31'd32,         1'b0, '0},
    '{REQ_DELETE, 31'd0,          1'b0, '0},
    '{REQ_DELETE, 31'd32,         1'b0, '0},
    '{REQ_DELETE, 31'd7,          1'b1, '{ST_NOFIND, 4'd7,  7'd0}},
    '{REQ_DELETE, 31'd16,         1'b0, '0},
    '{REQ_INSERT, 31'h2AAAAAAA,   1'b0, '0},
    '{REQ_INSERT, 31'h55555555,   1'b0, '0},
    '{REQ_DELETE, 31'h7FFFFFFF,   1'b1, '{ST_DONE,   4'd15, 7'd1}},
    '{REQ_DELETE, 31'h2AAAAAAA,   1'b0, '0},
    '{REQ_INSERT, 31'h7FFFFFF0,   1'b0, '0},
    '{REQ_DELETE, 31'h7FFFFFF0,   1'b0, '0},
    '{REQ_DELETE, 31'h55555555,   1'b0, '0},
    '{REQ_DELETE, 31'h55555555,   1'b1, '{ST_NOFIND, 4'd5,  7'd0}}
  };

  initial begin : stimulus
    key_t k;
    int   bkt;
    shadow_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests.
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);
    end
    drain();

    // Mixed traffic: mostly keys from a small set so deletes find matches,
    // some keys over the whole range.
    for (int i = 0; i < 200; i++) begin
      no_gaps = (i >= 80 && i < 120);
      if ($urandom_range(0, 4) == 0) k = key_t'($urandom);
      else k = key_t'($urandom_range(0, 63));
      send_request(($urandom_range(0, 9) < 6) ? REQ_INSERT : REQ_DELETE, k);
    end
    no_gaps = 1'b0;

    // Empty the table, then build one 64-node chain of a single key, overflow
    // the pool and remove the whole chain at once.
    clear_table();
    k = key_t'($urandom);
    for (int i = 0; i < NPOOL + 3; i++) send_request(REQ_INSERT, k);
    send_request(REQ_DELETE, k);
    drain();

    // Fill the pool with a mix of keys, keep inserting past full, then clear.
    for (int i = 0; i < NPOOL + 8; i++) begin
      send_request(REQ_INSERT, key_t'($urandom_range(0, 47)));
    end
    send_request(REQ_DELETE, key_t'($urandom_range(0, 47)));
    clear_table();

    // Collision-heavy traffic in a few buckets, with some noise on top.
    for (int i = 0; i < 120; i++) begin
      bkt = $urandom_range(0, 2) * 5;
      if ($urandom_range(0, 9) == 0) k = key_t'($urandom);
      else k = key_t'(($urandom_range(0, 5) << 4) | bkt);
      send_request(($urandom_range(0, 9) < 6) ? REQ_INSERT : REQ_DELETE, k);
    end

    // Let the last results arrive and give the block time for any stray one.
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    $display("Covered %0d inserts (%0d refused on a full pool) and %0d deletes",
             n_insert, n_full, n_delete);
    $display("(%0d with no match); the largest single delete removed %0d nodes.",
             n_nofind, max_removed);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/cht_pkg.sv
sv/cht_ram.sv
sv/cht_mod.sv
sv/chained_hash_table_core.sv
test/tb.sv
